[rtl/core/array_linked_list_manager_macros.svh]
// Assertion macros used by the checker of the linked list manager.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ARRAY_LINKED_LIST_MANAGER_MACROS_SVH
`define ARRAY_LINKED_LIST_MANAGER_MACROS_SVH

`define ALLM_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("allm check failed");

`define ALLM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("allm check failed");

`endif

[rtl/core/allm_pkg.sv]
// Shared constants, command and status codes and sequencer states
// for the linked list manager. No dependencies.
`default_nettype none

package allm_pkg;

    localparam int NODE_COUNT = 32;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W = $clog2(NODE_COUNT);
    localparam int STEP_W = IDX_W + 1;

    typedef enum logic [3:0] {
        CMD_ADD_FIRST = 4'd0,
        CMD_ADD_LAST  = 4'd1,
        CMD_REM_FIRST = 4'd2,
        CMD_REM_LAST  = 4'd3,
        CMD_REM_AT    = 4'd4,
        CMD_REM_CUR   = 4'd5,
        CMD_SEARCH    = 4'd6,
        CMD_NEXT      = 4'd7,
        CMD_CLEAR     = 4'd8
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_AT_END = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_ALLOC,
        S_ALLOC_WT,
        S_LINK,
        S_LINK2,
        S_DF_RD,
        S_DF_WT,
        S_CLR,
        S_RL_RD,
        S_RL_WT,
        S_RL_END,
        S_RA_RD,
        S_RA_WT,
        S_RA_LWT,
        S_SR_RD,
        S_SR_WT,
        S_NX_RD,
        S_NX_WT,
        S_FIN,
        S_OUT
    } state_t;

endpackage

`default_nettype wire

[rtl/core/allm_ram.sv]
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none

module allm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[rtl/core/array_linked_list_manager.sv]
// Linked list manager: a singly linked list kept in a fixed node store.
// Depends on allm_pkg and allm_ram.
//
// Usage: one command enters on the input channel (in_valid, in_ready with
// command, value and node_index) and exactly one result leaves on the
// output channel (out_valid, out_ready with status, result_node and
// result_data). Each transfer completes when valid and ready are both high.
// Commands are processed one at a time by a small sequencer that steps
// through the node store, one RAM read per step. An add takes a freed node
// if there is one, else the next node above the high-water mark. Remove last,
// remove at, remove current, search and clear walk the list one node at a
// time. in_ready is high only while the sequencer is idle, from the cycle
// the result is registered. The result register keeps a finished result
// while the receiver stalls, and the next command may be accepted
// meanwhile; its result waits until the first is taken.
// Reset empties the list and the free list; the node RAMs are not cleared
// and need no clearing pass.
`default_nettype none

module array_linked_list_manager
    import allm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [3:0]  command,
    input  wire logic [31:0] value,
    input  wire logic [4:0]  node_index,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       status,
    output logic [4:0]       result_node,
    output logic [31:0]      result_data
);

    localparam logic [IDX_W-1:0]  LAST_NODE = IDX_W'(NODE_COUNT - 1);
    localparam logic [STEP_W-1:0] STEP_MAX  = STEP_W'(NODE_COUNT);

    state_t state_reg, state_next;
    logic [3:0]            cmd_reg, cmd_next;
    logic [DATA_WIDTH-1:0] value_reg, value_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic                  idx_ok_reg, idx_ok_next;
    logic [IDX_W-1:0]      head_reg, head_next;
    logic [IDX_W-1:0]      tail_reg, tail_next;
    logic [IDX_W-1:0]      cur_reg, cur_next;
    logic [IDX_W-1:0]      fhead_reg, fhead_next;
    logic [IDX_W-1:0]      hw_reg, hw_next;
    logic [IDX_W-1:0]      ptr_reg, ptr_next;
    logic [IDX_W-1:0]      pre_reg, pre_next;
    logic [IDX_W-1:0]      node_reg, node_next;
    logic [STEP_W-1:0]     steps_reg, steps_next;
    status_t               status_reg, status_next;
    logic                  out_valid_reg, out_valid_next;
    logic [1:0]            out_status_reg, out_status_next;
    logic [4:0]            out_node_reg, out_node_next;
    logic [31:0]           out_data_reg, out_data_next;

    logic                  d_we, l_we, f_we;
    logic [IDX_W-1:0]      d_waddr, d_raddr, l_waddr, l_raddr, f_waddr, f_raddr;
    logic [DATA_WIDTH-1:0] d_wdata, d_rdata;
    logic [IDX_W-1:0]      l_wdata, l_rdata, f_wdata, f_rdata;

    logic accept, out_free, steps_left;

    assign in_ready    = (state_reg == S_IDLE);
    assign accept      = in_valid && in_ready;
    assign out_free    = !out_valid_reg || out_ready;
    assign steps_left  = (steps_reg < STEP_MAX);
    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign result_node = out_node_reg;
    assign result_data = out_data_reg;

    allm_ram #(.WIDTH(DATA_WIDTH), .DEPTH(NODE_COUNT)) u_data (
        .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
        .raddr(d_raddr), .rdata(d_rdata)
    );

    allm_ram #(.WIDTH(IDX_W), .DEPTH(NODE_COUNT)) u_link (
        .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
        .raddr(l_raddr), .rdata(l_rdata)
    );

    allm_ram #(.WIDTH(IDX_W), .DEPTH(NODE_COUNT)) u_free (
        .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
        .raddr(f_raddr), .rdata(f_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (cmd_reg)
                    CMD_ADD_FIRST, CMD_ADD_LAST:
                        state_next = S_ALLOC;
                    CMD_REM_FIRST, CMD_REM_LAST:
                        state_next = (head_reg == '0) ? S_FIN : S_DF_RD;
                    CMD_REM_AT:
                    begin
                        if (head_reg == '0 || !idx_ok_reg)
                            state_next = S_FIN;
                        else
                            state_next = (idx_reg == head_reg) ? S_DF_RD : S_RA_RD;
                    end
                    CMD_REM_CUR:
                    begin
                        if (head_reg == '0 || cur_reg == '0)
                            state_next = S_FIN;
                        else
                            state_next = (cur_reg == head_reg) ? S_DF_RD : S_RA_RD;
                    end
                    CMD_SEARCH:
                        state_next = S_SR_RD;
                    CMD_NEXT:
                        state_next = (cur_reg == '0) ? S_FIN : S_NX_RD;
                    CMD_CLEAR:
                        state_next = S_CLR;
                    default:
                        state_next = S_FIN;
                endcase
            end
            S_ALLOC:
            begin
                if (fhead_reg != '0)
                    state_next = S_ALLOC_WT;
                else if (hw_reg != LAST_NODE)
                    state_next = S_LINK;
                else
                    state_next = S_FIN;
            end
            S_ALLOC_WT:
                state_next = S_LINK;
            S_LINK:
            begin
                if (cmd_reg == CMD_ADD_FIRST || head_reg == '0)
                    state_next = S_FIN;
                else
                    state_next = S_LINK2;
            end
            S_LINK2:
                state_next = S_FIN;
            S_DF_RD:
                state_next = S_DF_WT;
            S_DF_WT:
            begin
                if (cmd_reg == CMD_REM_LAST && l_rdata != '0)
                    state_next = S_RL_RD;
                else if (cmd_reg == CMD_CLEAR)
                    state_next = S_CLR;
                else
                    state_next = S_FIN;
            end
            S_CLR:
                state_next = (steps_left && head_reg != '0) ? S_DF_WT : S_FIN;
            S_RL_RD:
                state_next = steps_left ? S_RL_WT : S_RL_END;
            S_RL_WT:
                state_next = (l_rdata != '0) ? S_RL_RD : S_RL_END;
            S_RL_END:
                state_next = S_FIN;
            S_RA_RD:
                state_next = steps_left ? S_RA_WT : S_FIN;
            S_RA_WT:
            begin
                if (l_rdata == idx_reg)
                    state_next = S_RA_LWT;
                else
                    state_next = (l_rdata == '0) ? S_FIN : S_RA_RD;
            end
            S_RA_LWT:
                state_next = S_FIN;
            S_SR_RD:
                state_next = (steps_left && ptr_reg != '0) ? S_SR_WT : S_FIN;
            S_SR_WT:
                state_next = (d_rdata == value_reg) ? S_FIN : S_SR_RD;
            S_NX_RD:
                state_next = S_NX_WT;
            S_NX_WT:
                state_next = S_FIN;
            S_FIN:
                state_next = S_OUT;
            S_OUT:
                state_next = out_free ? S_IDLE : S_OUT;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd_next        = cmd_reg;
        value_next      = value_reg;
        idx_next        = idx_reg;
        idx_ok_next     = idx_ok_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        cur_next        = cur_reg;
        fhead_next      = fhead_reg;
        hw_next         = hw_reg;
        ptr_next        = ptr_reg;
        pre_next        = pre_reg;
        node_next       = node_reg;
        steps_next      = steps_reg;
        status_next     = status_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_node_next   = out_node_reg;
        out_data_next   = out_data_reg;
        d_we = 1'b0;  d_waddr = '0;  d_wdata = '0;  d_raddr = '0;
        l_we = 1'b0;  l_waddr = '0;  l_wdata = '0;  l_raddr = '0;
        f_we = 1'b0;  f_waddr = '0;  f_wdata = '0;  f_raddr = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next    = command;
                    value_next  = DATA_WIDTH'(value);
                    idx_next    = IDX_W'(node_index);
                    idx_ok_next = (node_index != 5'd0) && (32'(node_index) < NODE_COUNT);
                end
            end
            S_DISPATCH:
            begin
                status_next = ST_OK;
                ptr_next    = head_reg;
                steps_next  = '0;
                case (cmd_reg)
                    CMD_REM_FIRST, CMD_REM_LAST:
                    begin
                        if (head_reg == '0)
                            status_next = ST_EMPTY;
                    end
                    CMD_REM_AT:
                    begin
                        if (head_reg == '0 || !idx_ok_reg)
                            status_next = ST_EMPTY;
                    end
                    CMD_REM_CUR:
                    begin
                        idx_next = cur_reg;
                        if (head_reg == '0 || cur_reg == '0)
                            status_next = ST_EMPTY;
                    end
                    CMD_NEXT:
                    begin
                        if (cur_reg == '0)
                            status_next = ST_AT_END;
                    end
                    default:
                    begin
                        status_next = ST_OK;
                    end
                endcase
            end
            S_ALLOC:
            begin
                if (fhead_reg != '0)
                begin
                    f_raddr = fhead_reg;
                end
                else if (hw_reg != LAST_NODE)
                begin
                    hw_next   = hw_reg + 1'b1;
                    node_next = hw_reg + 1'b1;
                end
                else
                begin
                    status_next = ST_FULL;
                end
            end
            S_ALLOC_WT:
            begin
                node_next  = fhead_reg;
                fhead_next = f_rdata;
            end
            S_LINK:
            begin
                d_we    = 1'b1;
                d_waddr = node_reg;
                d_wdata = value_reg;
                l_we    = 1'b1;
                l_waddr = node_reg;
                if (cmd_reg == CMD_ADD_FIRST || head_reg == '0)
                begin
                    l_wdata   = head_reg;
                    head_next = node_reg;
                    cur_next  = node_reg;
                    if (head_reg == '0)
                        tail_next = node_reg;
                end
                else
                begin
                    l_wdata = '0;
                end
            end
            S_LINK2:
            begin
                l_we      = 1'b1;
                l_waddr   = tail_reg;
                l_wdata   = node_reg;
                tail_next = node_reg;
                cur_next  = node_reg;
            end
            S_DF_RD:
            begin
                l_raddr = head_reg;
            end
            S_DF_WT:
            begin
                if (cmd_reg == CMD_REM_LAST && l_rdata != '0)
                begin
                    pre_next   = head_reg;
                    ptr_next   = l_rdata;
                    steps_next = STEP_W'(1);
                end
                else
                begin
                    f_we       = 1'b1;
                    f_waddr    = head_reg;
                    f_wdata    = fhead_reg;
                    fhead_next = head_reg;
                    head_next  = l_rdata;
                    cur_next   = l_rdata;
                    if (l_rdata == '0)
                        tail_next = '0;
                end
            end
            S_CLR:
            begin
                if (steps_left && head_reg != '0)
                begin
                    steps_next = steps_reg + 1'b1;
                    l_raddr    = head_reg;
                end
                else
                begin
                    head_next = '0;
                    tail_next = '0;
                    cur_next  = '0;
                end
            end
            S_RL_RD:
            begin
                l_raddr = ptr_reg;
            end
            S_RL_WT:
            begin
                if (l_rdata != '0)
                begin
                    pre_next   = ptr_reg;
                    ptr_next   = l_rdata;
                    steps_next = steps_reg + 1'b1;
                end
            end
            S_RL_END:
            begin
                l_we       = 1'b1;
                l_waddr    = pre_reg;
                l_wdata    = '0;
                f_we       = 1'b1;
                f_waddr    = ptr_reg;
                f_wdata    = fhead_reg;
                fhead_next = ptr_reg;
                cur_next   = pre_reg;
                tail_next  = pre_reg;
            end
            S_RA_RD:
            begin
                if (steps_left)
                    l_raddr = ptr_reg;
                else
                    status_next = ST_EMPTY;
            end
            S_RA_WT:
            begin
                if (l_rdata == idx_reg)
                begin
                    l_raddr = idx_reg;
                end
                else
                begin
                    ptr_next   = l_rdata;
                    steps_next = steps_reg + 1'b1;
                    if (l_rdata == '0)
                        status_next = ST_EMPTY;
                end
            end
            S_RA_LWT:
            begin
                l_we       = 1'b1;
                l_waddr    = ptr_reg;
                l_wdata    = l_rdata;
                f_we       = 1'b1;
                f_waddr    = idx_reg;
                f_wdata    = fhead_reg;
                fhead_next = idx_reg;
                cur_next   = ptr_reg;
                if (tail_reg == idx_reg)
                    tail_next = ptr_reg;
            end
            S_SR_RD:
            begin
                if (steps_left && ptr_reg != '0)
                begin
                    d_raddr = ptr_reg;
                    l_raddr = ptr_reg;
                end
                else
                begin
                    status_next = ST_EMPTY;
                end
            end
            S_SR_WT:
            begin
                if (d_rdata == value_reg)
                begin
                    cur_next = ptr_reg;
                end
                else
                begin
                    ptr_next   = l_rdata;
                    steps_next = steps_reg + 1'b1;
                end
            end
            S_NX_RD:
            begin
                l_raddr = cur_reg;
            end
            S_NX_WT:
            begin
                if (l_rdata == '0)
                    status_next = ST_AT_END;
                else
                    cur_next = l_rdata;
            end
            S_FIN:
            begin
                d_raddr = cur_reg;
            end
            S_OUT:
            begin
                d_raddr = cur_reg;
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_node_next   = 5'(cur_reg);
                    out_data_next   = (cur_reg != '0) ? 32'(d_rdata) : 32'd0;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            cur_reg       <= '0;
            fhead_reg     <= '0;
            hw_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            cur_reg       <= cur_next;
            fhead_reg     <= fhead_next;
            hw_reg        <= hw_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        value_reg      <= value_next;
        idx_reg        <= idx_next;
        idx_ok_reg     <= idx_ok_next;
        ptr_reg        <= ptr_next;
        pre_reg        <= pre_next;
        node_reg       <= node_next;
        steps_reg      <= steps_next;
        status_reg     <= status_next;
        out_status_reg <= out_status_next;
        out_node_reg   <= out_node_next;
        out_data_reg   <= out_data_next;
    end

endmodule

`default_nettype wire

[rtl/core/allm_checker.sv]
// Port-level checks for the linked list manager, bound to the top level.
// Depends on array_linked_list_manager_macros.svh.
`default_nettype none
`include "array_linked_list_manager_macros.svh"

module allm_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic [3:0]  command,
    input wire logic [31:0] value,
    input wire logic [4:0]  node_index,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [1:0]  status,
    input wire logic [4:0]  result_node,
    input wire logic [31:0] result_data
);

    // A command occupies the sequencer after its transfer, so in_ready drops.
    `ALLM_ASSERT_NEXT(chk_busy_after_accept, in_valid && in_ready, !in_ready)

    `ALLM_ASSERT_NEXT(chk_result_held, out_valid && !out_ready, out_valid && $stable(status) && $stable(result_node) && $stable(result_data))

    // A null current node always carries zero data.
    `ALLM_ASSERT_SAME(chk_null_data, out_valid && result_node == 5'd0, result_data == 32'd0)

    // After S_DISPATCH the block is still busy with the command it took.
    `ALLM_ASSERT_NEXT(chk_min_latency, in_valid && in_ready, ##1 !in_ready)

endmodule

bind array_linked_list_manager allm_checker u_allm_checker (.*);

`default_nettype wire

[verif/tb.sv]
// Self-checking testbench for array_linked_list_manager: drives list commands, predicts
// each status, current node and data, and checks every result transfer in order.
// Depends on allm_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb;
    import allm_pkg::*;

    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  node;
        logic [31:0] data;
    } list_result_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [3:0]  command;
    logic [31:0] value;
    logic [4:0]  node_index;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic [4:0]  result_node;
    logic [31:0] result_data;

    list_result_t awaited_results[$];
    logic [31:0]  value_pool[8];
    int  error_count = 0;
    bit  steady = 0;
    bit  hold_request = 0;
    int  hold_left = 0;

    logic [31:0] mdl_data[NODE_COUNT];
    logic [4:0]  mdl_link[NODE_COUNT];
    logic [4:0]  mdl_free[NODE_COUNT];
    logic [4:0]  mdl_head, mdl_tail, mdl_cur, mdl_free_head, mdl_high;
    int          mdl_len;

    array_linked_list_manager dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .command(command), .value(value), .node_index(node_index),
        .out_valid(out_valid), .out_ready(out_ready), .status(status),
        .result_node(result_node), .result_data(result_data)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    initial
    begin
        #20_000_000;
        $display("** array_linked_list_manager: FAILED **");
        $finish;
    end

    function automatic logic [4:0] take_node();
        logic [4:0] n;
        if (mdl_free_head != 0)
        begin
            n = mdl_free_head;
            mdl_free_head = mdl_free[n];
            return n;
        end
        if (mdl_high < NODE_COUNT - 1)
        begin
            mdl_high++;
            return mdl_high;
        end
        return 5'd0;
    endfunction

    function automatic void give_node(logic [4:0] n);
        mdl_free[n] = mdl_free_head;
        mdl_free_head = n;
        mdl_len--;
    endfunction

    function automatic void drop_head();
        logic [4:0] nx;
        nx = mdl_link[mdl_head];
        give_node(mdl_head);
        mdl_head = nx;
        mdl_cur = nx;
        if (nx == 0)
            mdl_tail = 0;
    endfunction

    function automatic logic [1:0] insert_node(bit at_front, logic [31:0] v);
        logic [4:0] n;
        n = take_node();
        if (n == 0)
            return ST_FULL;
        mdl_len++;
        mdl_data[n] = v;
        if (at_front || mdl_head == 0)
        begin
            mdl_link[n] = mdl_head;
            if (mdl_head == 0)
                mdl_tail = n;
            mdl_head = n;
        end
        else
        begin
            mdl_link[n] = 0;
            mdl_link[mdl_tail] = n;
            mdl_tail = n;
        end
        mdl_cur = n;
        return ST_OK;
    endfunction

    function automatic logic [1:0] unlink_node(logic [4:0] p);
        logic [4:0] ptr;
        if (mdl_head == 0 || p == 0)
            return ST_EMPTY;
        if (p == mdl_head)
        begin
            drop_head();
            return ST_OK;
        end
        ptr = mdl_head;
        for (int s = 0; s < NODE_COUNT; s++)
        begin
            if (mdl_link[ptr] == p)
            begin
                mdl_link[ptr] = mdl_link[p];
                if (mdl_tail == p)
                    mdl_tail = ptr;
                give_node(p);
                mdl_cur = ptr;
                return ST_OK;
            end
            ptr = mdl_link[ptr];
            if (ptr == 0)
                return ST_EMPTY;
        end
        return ST_EMPTY;
    endfunction

    function automatic list_result_t predict_result(logic [3:0] c, logic [31:0] v,
                                                    logic [4:0] p);
        list_result_t r;
        logic [1:0]   st;
        logic [4:0]   ptr;
        logic [4:0]   pre;
        st = ST_OK;
        case (c)
            CMD_ADD_FIRST: st = insert_node(1'b1, v);
            CMD_ADD_LAST:  st = insert_node(1'b0, v);
            CMD_REM_FIRST:
                if (mdl_head == 0)
                    st = ST_EMPTY;
                else
                    drop_head();
            CMD_REM_LAST:
                if (mdl_head == 0)
                    st = ST_EMPTY;
                else if (mdl_link[mdl_head] == 0)
                    drop_head();
                else
                begin
                    pre = mdl_head;
                    ptr = mdl_head;
                    for (int s = 0; s < NODE_COUNT && mdl_link[ptr] != 0; s++)
                    begin
                        pre = ptr;
                        ptr = mdl_link[ptr];
                    end
                    mdl_link[pre] = 0;
                    give_node(ptr);
                    mdl_cur = pre;
                    mdl_tail = pre;
                end
            CMD_REM_AT:  st = unlink_node(p);
            CMD_REM_CUR: st = unlink_node(mdl_cur);
            CMD_SEARCH:
            begin
                st = ST_EMPTY;
                ptr = mdl_head;
                for (int s = 0; s < NODE_COUNT && ptr != 0 && st != ST_OK; s++)
                begin
                    if (mdl_data[ptr] == v)
                    begin
                        mdl_cur = ptr;
                        st = ST_OK;
                    end
                    ptr = mdl_link[ptr];
                end
            end
            CMD_NEXT:
                if (mdl_cur == 0 || mdl_link[mdl_cur] == 0)
                    st = ST_AT_END;
                else
                    mdl_cur = mdl_link[mdl_cur];
            CMD_CLEAR:
            begin
                for (int s = 0; s < NODE_COUNT && mdl_head != 0; s++)
                    drop_head();
                mdl_head = 0;
                mdl_tail = 0;
                mdl_cur = 0;
            end
            default: st = ST_OK;
        endcase
        r.status = st;
        r.node = mdl_cur;
        r.data = (mdl_cur != 0) ? mdl_data[mdl_cur] : 32'd0;
        return r;
    endfunction

    // Called just after a falling edge; returns just after the falling edge that
    // follows the transfer, with in_valid still high.
    task automatic send_command(logic [3:0] c, logic [31:0] v, logic [4:0] p);
        while (!steady && $urandom_range(99) < 26)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        command <= c;
        value <= v;
        node_index <= p;
        do
            @(posedge clk);
        while (!in_ready);
        awaited_results.push_back(predict_result(c, v, p));
        @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left = 300;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= steady || ($urandom_range(99) >= 26);
    end

    always @(posedge clk)
    begin
        list_result_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            if (awaited_results.size() == 0)
            begin
                $error("result transfer with no command outstanding");
                error_count++;
            end
            else
            begin
                exp_r = awaited_results.pop_front();
                if (status !== exp_r.status)
                begin
                    $error("status: expected %0d, got %0d", exp_r.status, status);
                    error_count++;
                end
                if (result_node !== exp_r.node)
                begin
                    $error("result_node: expected %0d, got %0d", exp_r.node, result_node);
                    error_count++;
                end
                if (result_data !== exp_r.data)
                begin
                    $error("result_data: expected %h, got %h", exp_r.data, result_data);
                    error_count++;
                end
            end
        end
    end

    task automatic test_directed();
        send_command(CMD_REM_FIRST, 32'd0, 5'd0);
        send_command(CMD_REM_LAST, 32'd0, 5'd0);
        send_command(CMD_REM_AT, 32'd0, 5'd1);
        send_command(CMD_REM_CUR, 32'd0, 5'd0);
        send_command(CMD_NEXT, 32'd0, 5'd0);
        send_command(CMD_SEARCH, 32'd0, 5'd0);
        send_command(CMD_ADD_FIRST, 32'hFFFF_FFFF, 5'd31);
        send_command(CMD_ADD_FIRST, 32'd0, 5'd0);
        send_command(CMD_ADD_LAST, 32'h8000_0001, 5'd0);
        send_command(CMD_SEARCH, 32'd0, 5'd0);
        send_command(CMD_NEXT, 32'd0, 5'd0);
        send_command(CMD_NEXT, 32'd0, 5'd0);
        send_command(CMD_NEXT, 32'd0, 5'd0);
        send_command(CMD_SEARCH, 32'h1234_5678, 5'd0);
        send_command(CMD_REM_AT, 32'd0, 5'd0);
        send_command(CMD_REM_AT, 32'd0, 5'd31);
        send_command(CMD_REM_AT, 32'd0, 5'd1);
        send_command(CMD_REM_CUR, 32'd0, 5'd0);
        send_command(4'd15, 32'hFFFF_FFFF, 5'd31);
        send_command(4'd9, 32'd0, 5'd0);
        send_command(CMD_ADD_LAST, 32'h5555_AAAA, 5'd0);
        send_command(CMD_REM_LAST, 32'd0, 5'd0);
        send_command(CMD_CLEAR, 32'd0, 5'd0);
        send_command(CMD_REM_LAST, 32'd0, 5'd0);
    endtask

    task automatic test_store_full();
        for (int i = 0; i < NODE_COUNT + 2; i++)
            send_command((i % 2) ? CMD_ADD_LAST : CMD_ADD_FIRST, $urandom, 5'd0);
        send_command(CMD_REM_LAST, 32'd0, 5'd0);
        send_command(CMD_REM_AT, 32'd0, 5'd16);
        send_command(CMD_ADD_FIRST, 32'hA5A5_A5A5, 5'd0);
        send_command(CMD_ADD_LAST, 32'h5A5A_5A5A, 5'd0);
        send_command(CMD_ADD_LAST, 32'h0F0F_0F0F, 5'd0);
        send_command(CMD_CLEAR, 32'd0, 5'd0);
    endtask

    task automatic test_output_stall();
        hold_request = 1'b1;
        for (int i = 0; i < 12; i++)
            send_command(CMD_ADD_LAST, $urandom, 5'($urandom_range(31)));
    endtask

    task automatic test_random_traffic();
        logic [3:0]  c;
        logic [31:0] v;
        int          pick;
        for (int i = 0; i < 8; i++)
            value_pool[i] = $urandom;
        for (int i = 0; i < 1650; i++)
        begin
            steady = (i >= 500 && i < 700);
            pick = $urandom_range(99);
            if (pick < 5)
                c = 4'($urandom_range(15, 9));
            else if (pick < 7)
                c = CMD_CLEAR;
            else if (pick < 45 && mdl_len < NODE_COUNT - 1 - $urandom_range(12))
                c = ($urandom_range(1)) ? CMD_ADD_LAST : CMD_ADD_FIRST;
            else
                c = 4'($urandom_range(7));
            v = ($urandom_range(1)) ? value_pool[$urandom_range(7)] : $urandom;
            send_command(c, v, 5'($urandom_range(31)));
        end
        steady = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        command = '0;
        value = '0;
        node_index = '0;
        for (int i = 0; i < NODE_COUNT; i++)
        begin
            mdl_data[i] = '0;
            mdl_link[i] = '0;
            mdl_free[i] = '0;
        end
        mdl_head = 0;
        mdl_tail = 0;
        mdl_cur = 0;
        mdl_free_head = 0;
        mdl_high = 0;
        mdl_len = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_store_full();
        test_output_stall();
        test_random_traffic();
        in_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (2 * NODE_COUNT + 20) @(posedge clk);
        if (error_count == 0)
            $display("** array_linked_list_manager: PASSED **");
        else
            $display("** array_linked_list_manager: FAILED **");
        $finish;
    end

endmodule
